FILE: hw/rtl/bfsp_pkg.sv
// Package with shared types, codes and constants of the brace format spec parser.
package bfsp_pkg;

  // Request codes of an input word.
  typedef enum logic [1:0] {
    ReqChar  = 2'd0,
    ReqBegin = 2'd1,
    ReqAfter = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  // Action codes of a result word.
  typedef enum logic [1:0] {
    ActFeed = 2'd0,
    ActItem = 2'd1,
    ActPass = 2'd2,
    ActCtrl = 2'd3
  } action_e;

  // Field widths of the payloads.
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ActW   = 2;
  localparam int unsigned NumW   = 16;
  localparam int unsigned FlagsW = 9;

  // Default accumulator width.
  localparam int unsigned DefValueBits = 16;

  // Flag bit positions.
  localparam int unsigned FlDec      = 0;
  localparam int unsigned FlOct      = 1;
  localparam int unsigned FlHex      = 2;
  localparam int unsigned FlLeft     = 3;
  localparam int unsigned FlRight    = 4;
  localparam int unsigned FlInternal = 5;
  localparam int unsigned FlSci      = 6;
  localparam int unsigned FlFixed    = 7;
  localparam int unsigned FlShowbase = 8;

  // Characters the parser reacts to.
  localparam logic [CharW-1:0] ChZero  = "0";
  localparam logic [CharW-1:0] ChNine  = "9";
  localparam logic [CharW-1:0] ChOpen  = "{";
  localparam logic [CharW-1:0] ChClose = "}";
  localparam logic [CharW-1:0] ChColon = ":";
  localparam logic [CharW-1:0] ChBang  = "!";
  localparam logic [CharW-1:0] ChMinus = "-";
  localparam logic [CharW-1:0] ChW     = "w";
  localparam logic [CharW-1:0] ChP     = "p";
  localparam logic [CharW-1:0] ChL     = "l";
  localparam logic [CharW-1:0] ChR     = "r";
  localparam logic [CharW-1:0] ChI     = "i";
  localparam logic [CharW-1:0] ChD     = "d";
  localparam logic [CharW-1:0] ChO     = "o";
  localparam logic [CharW-1:0] ChB     = "b";
  localparam logic [CharW-1:0] ChH     = "h";
  localparam logic [CharW-1:0] ChS     = "s";
  localparam logic [CharW-1:0] ChF     = "f";
  localparam logic [CharW-1:0] ChX     = "x";

  // One output format.
  typedef struct packed {
    logic [NumW-1:0]   width;
    logic [NumW-1:0]   precision;
    logic [CharW-1:0]  fill;
    logic [FlagsW-1:0] flags;
  } fmt_t;

  localparam fmt_t FmtReset = '{
    width:     NumW'(0),
    precision: NumW'(6),
    fill:      CharW'(8'h20),
    flags:     FlagsW'(1) << FlDec
  };

endpackage

FILE: hw/rtl/bfsp_if.sv
// Valid/ready channel interfaces for the input and result words of the parser.
interface bfsp_in_if
  import bfsp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [CharW-1:0] char_in;
  logic             escaped;

  modport source (output valid, output req_type, output char_in, output escaped,
                  input ready);
  modport sink   (input valid, input req_type, input char_in, input escaped,
                  output ready);
endinterface

interface bfsp_out_if
  import bfsp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [NumW-1:0]   arg_index;
  logic              arg_index_valid;
  logic [NumW-1:0]   field_width;
  logic [NumW-1:0]   field_precision;
  logic [CharW-1:0]  fill_char;
  logic [FlagsW-1:0] format_flags;
  logic              keep_flag;

  modport source (output valid, output action, output arg_index, output arg_index_valid,
                  output field_width, output field_precision, output fill_char,
                  output format_flags, output keep_flag, input ready);
  modport sink   (input valid, input action, input arg_index, input arg_index_valid,
                  input field_width, input field_precision, input fill_char,
                  input format_flags, input keep_flag, output ready);
endinterface

FILE: hw/rtl/brace_format_spec_parser.sv
// Top level of the brace format spec parser: input register, parse step, result register.
//
// Usage: words enter on in_i, one per character of a format string (req_type char),
// or as control events (begin saves the current format, after restores it unless
// the keep mark "!" was seen). Every accepted input word yields exactly one result
// word on out_o, carrying the action (feed, do item, pass through, control done),
// the parsed argument index and the current width, precision, fill and flags.
// The word is captured in an input register, and from there one pass of decode plus a
// multiply-by-ten-and-add updates the parser state and loads the result register.
// Throughput is one word per cycle while out_o takes its words; the parse state
// feeds straight back into the next word's update, so no two words are ever in the
// update logic at once.
// When the receiver stalls, the result register holds its word and the input register
// still takes one more word, after which in_i.ready drops until out_o drains.
// Reset (rst_ni low) empties both registers, leaves index and format mode, clears the
// keep mark and accumulators, and sets width 0, precision 6, fill space, decimal base,
// with the saved format equal to that default.
module brace_format_spec_parser
  import bfsp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfsp_in_if.sink   in_i,
  bfsp_out_if.source out_o
);

  localparam int unsigned AccW = VALUE_BITS;
  // Width wide enough to compare an accumulator against the 16-bit field top.
  localparam int unsigned SatW = (AccW > NumW) ? AccW : NumW;

  typedef logic [AccW-1:0] acc_t;

  // Appends one decimal digit to an accumulator and saturates at its top value.
  function automatic acc_t take_digit(input logic vld, input acc_t val,
                                      input logic [3:0] dig);
    logic [AccW+3:0] wide;
    wide = ({4'b0, val} << 3) + ({4'b0, val} << 1) + (AccW+4)'(dig);
    if (!vld) begin
      return AccW'(dig);
    end else if (wide[AccW+3:AccW] != 4'b0) begin
      return '1;
    end else begin
      return wide[AccW-1:0];
    end
  endfunction

  // Clamps an accumulator to the 16-bit field range.
  function automatic logic [NumW-1:0] sat_num(input acc_t val);
    logic [SatW-1:0] ext;
    ext = SatW'(val);
    if (ext > SatW'({NumW{1'b1}})) begin
      return '1;
    end else begin
      return ext[NumW-1:0];
    end
  endfunction

  // Input register.
  logic             in_vld_q;
  logic [ReqW-1:0]  req_q;
  logic [CharW-1:0] ch_q;
  logic             esc_q;

  // Parse state.
  logic in_index_q, in_index_d;
  logic in_format_q, in_format_d;
  logic idx_vld_q, idx_vld_d;
  acc_t idx_val_q, idx_val_d;
  logic val_vld_q, val_vld_d;
  acc_t val_val_q, val_val_d;
  logic keep_q, keep_d;
  fmt_t cur_q, cur_d;
  fmt_t saved_q, saved_d;

  // Result register.
  logic    out_vld_q;
  action_e act_d, act_q;
  logic [NumW-1:0] idx_out_q;
  logic            idx_out_vld_q;
  fmt_t            fmt_out_q;
  logic            keep_out_q;

  logic advance;
  logic is_digit;
  logic go_fmt;

  // The input stage hands its word on whenever the result register is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign is_digit   = (ch_q >= ChZero) && (ch_q <= ChNine);

  always_comb begin
    in_index_d  = in_index_q;
    in_format_d = in_format_q;
    idx_vld_d   = idx_vld_q;
    idx_val_d   = idx_val_q;
    val_vld_d   = val_vld_q;
    val_val_d   = val_val_q;
    keep_d      = keep_q;
    cur_d       = cur_q;
    saved_d     = saved_q;
    act_d       = ActCtrl;
    go_fmt      = 1'b0;

    unique case (req_e'(req_q))
      ReqChar: begin
        act_d = ActFeed;
        if (esc_q) begin
          // An escape is fill in a spec, opens the format part in an index, else passes.
          if (in_format_q) begin
            cur_d.fill = ch_q;
          end else if (in_index_q) begin
            in_index_d  = 1'b0;
            in_format_d = 1'b1;
            go_fmt      = 1'b1;
          end else begin
            act_d = ActPass;
          end
        end else if (in_index_q) begin
          if (is_digit) begin
            idx_val_d = take_digit(idx_vld_q, idx_val_q, 4'(ch_q - ChZero));
            idx_vld_d = 1'b1;
          end else if (ch_q == ChClose) begin
            act_d = ActItem;
          end else begin
            in_index_d  = 1'b0;
            in_format_d = 1'b1;
            go_fmt      = (ch_q != ChColon);
          end
        end else if (in_format_q) begin
          go_fmt = 1'b1;
        end else if (ch_q == ChOpen) begin
          in_index_d = 1'b1;
          idx_vld_d  = 1'b0;
          idx_val_d  = '0;
        end else begin
          act_d = ActPass;
        end

        if (go_fmt) begin
          if (is_digit) begin
            val_val_d = take_digit(val_vld_q, val_val_q, 4'(ch_q - ChZero));
            val_vld_d = 1'b1;
          end else begin
            // Every non-digit in the format part consumes the pending value.
            val_vld_d = 1'b0;
            val_val_d = '0;
            unique case (ch_q)
              ChClose: begin
                if (val_vld_q) cur_d.width = sat_num(val_val_q);
                act_d = ActItem;
              end
              ChBang:  keep_d = 1'b1;
              ChMinus: ;
              ChW: if (val_vld_q) cur_d.width = sat_num(val_val_q);
              ChP: if (val_vld_q) cur_d.precision = sat_num(val_val_q);
              ChL: begin
                if (val_vld_q) cur_d.width = sat_num(val_val_q);
                cur_d.flags[FlLeft] = 1'b1;
              end
              ChR: begin
                if (val_vld_q) cur_d.width = sat_num(val_val_q);
                cur_d.flags[FlRight] = 1'b1;
              end
              ChI: begin
                if (val_vld_q) cur_d.width = sat_num(val_val_q);
                cur_d.flags[FlInternal] = 1'b1;
              end
              ChD: cur_d.flags[FlHex:FlDec] = 3'b001;
              ChO: cur_d.flags[FlHex:FlDec] = 3'b010;
              ChB, ChH: cur_d.flags[FlHex:FlDec] = 3'b100;
              ChS: cur_d.flags[FlSci] = 1'b1;
              ChF: cur_d.flags[FlFixed] = 1'b1;
              ChX: cur_d.flags[FlShowbase] = 1'b1;
              default: cur_d.fill = ch_q;
            endcase
          end
        end
      end
      ReqBegin, ReqAfter: begin
        if (req_e'(req_q) == ReqBegin) begin
          saved_d = cur_q;
        end else if (!keep_q) begin
          cur_d = saved_q;
        end
        in_index_d  = 1'b0;
        in_format_d = 1'b0;
        idx_vld_d   = 1'b0;
        idx_val_d   = '0;
        val_vld_d   = 1'b0;
        val_val_d   = '0;
        keep_d      = 1'b0;
      end
      default: ;
    endcase
  end

  // Input register control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q <= in_i.req_type;
      ch_q  <= in_i.char_in;
      esc_q <= in_i.escaped;
    end
  end

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_index_q  <= 1'b0;
      in_format_q <= 1'b0;
      idx_vld_q   <= 1'b0;
      idx_val_q   <= '0;
      val_vld_q   <= 1'b0;
      val_val_q   <= '0;
      keep_q      <= 1'b0;
      cur_q       <= FmtReset;
      saved_q     <= FmtReset;
    end else if (advance) begin
      in_index_q  <= in_index_d;
      in_format_q <= in_format_d;
      idx_vld_q   <= idx_vld_d;
      idx_val_q   <= idx_val_d;
      val_vld_q   <= val_vld_d;
      val_val_q   <= val_val_d;
      keep_q      <= keep_d;
      cur_q       <= cur_d;
      saved_q     <= saved_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act_q         <= act_d;
      idx_out_q     <= idx_vld_d ? sat_num(idx_val_d) : '0;
      idx_out_vld_q <= idx_vld_d;
      fmt_out_q     <= cur_d;
      keep_out_q    <= keep_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.action          = act_q;
  assign out_o.arg_index       = idx_out_q;
  assign out_o.arg_index_valid = idx_out_vld_q;
  assign out_o.field_width     = fmt_out_q.width;
  assign out_o.field_precision = fmt_out_q.precision;
  assign out_o.fill_char       = fmt_out_q.fill;
  assign out_o.format_flags    = fmt_out_q.flags;
  assign out_o.keep_flag       = keep_out_q;

endmodule

FILE: tb/brace_format_spec_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the brace format spec parser, with its own parse model.
module brace_format_spec_parser_test
  import bfsp_pkg::*;
();

  // Accumulator width of the block under test, and the value the accumulators stop at.
  localparam int unsigned     ValueBits = DefValueBits;
  localparam longint unsigned AccTop    = (64'd1 << ValueBits) - 64'd1;

  // Stimulus sizes and run limits.
  localparam int unsigned DirCount    = 28;
  localparam int unsigned RandWords   = 420;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned ReportLimit = 10;

  // The three base bits are mutually exclusive, the other flags accumulate.
  localparam logic [FlagsW-1:0] BaseMask =
      FlagsW'((1 << FlDec) | (1 << FlOct) | (1 << FlHex));

  // One input word as the stimulus holds it. When chk_dflt is set the result is known
  // without the model: the default format, no index, no keep mark and action dflt_act.
  typedef struct packed {
    req_e             req;
    logic [CharW-1:0] ch;
    logic             esc;
    logic             chk_dflt;
    action_e          dflt_act;
  } in_word_t;

  // One result word as the model predicts it.
  typedef struct packed {
    action_e         action;
    logic [NumW-1:0] arg_index;
    logic            arg_valid;
    fmt_t            fmt;
    logic            keep;
  } parse_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bfsp_in_if  in_if ();
  bfsp_out_if out_if ();

  brace_format_spec_parser #(
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus, the results still owed by the block, and run bookkeeping.
  in_word_t      stim[$];
  in_word_t      dir_rows[DirCount];
  parse_result_t pending_results[$];
  int            send_ptr     = 0;
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  logic [1:0]    idle_phase   = 2'd0;

  // Parser model state. Each accumulator is a seen bit plus a value.
  logic            idx_mode;
  logic            spec_mode;
  logic            idx_seen;
  logic            val_seen;
  logic            keep_mark;
  longint unsigned idx_acc;
  longint unsigned val_acc;
  fmt_t            cur_fmt;
  fmt_t            saved_fmt;

  // Characters that mean something inside a spec; other non-digits but } become the fill.
  logic [CharW-1:0] spec_chars[14] = '{ChW, ChP, ChL, ChR, ChI, ChD, ChO, ChB, ChH,
                                       ChS, ChF, ChX, ChBang, ChMinus};

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Decimal accumulate that sticks at the top of the accumulator width.
  function automatic longint unsigned add_digit(logic seen, longint unsigned acc,
                                                logic [CharW-1:0] c);
    longint unsigned n;
    if (!seen) begin
      n = c - ChZero;
      return n;
    end
    n = acc * 10 + (c - ChZero);
    return (n > AccTop) ? AccTop : n;
  endfunction

  // Outputs are 16 bits wide, so a wider accumulator is clipped on the way out.
  function automatic logic [NumW-1:0] sat_num(longint unsigned v);
    return (v > 64'hFFFF) ? '1 : NumW'(v);
  endfunction

  function automatic void clear_value();
    val_seen = 1'b0;
    val_acc  = 0;
  endfunction

  // Width and precision only change when a value was actually typed.
  function automatic void apply_value(logic as_prec);
    if (val_seen) begin
      if (as_prec) begin
        cur_fmt.precision = sat_num(val_acc);
      end else begin
        cur_fmt.width = sat_num(val_acc);
      end
    end
    clear_value();
  endfunction

  // Leaves index and spec mode and forgets everything parsed so far, not the format.
  function automatic void leave_spec();
    idx_mode  = 1'b0;
    idx_seen  = 1'b0;
    idx_acc   = 0;
    spec_mode = 1'b0;
    keep_mark = 1'b0;
    clear_value();
  endfunction

  // One character of the format string.
  function automatic action_e parse_char(logic [CharW-1:0] ch, logic esc);
    // An escaped character is fill inside a spec, ends the index part inside an index,
    // and is plain text outside any brace.
    if (esc) begin
      if (spec_mode) begin
        cur_fmt.fill = ch;
        return ActFeed;
      end else if (idx_mode) begin
        idx_mode  = 1'b0;
        spec_mode = 1'b1;
      end else begin
        return ActPass;
      end
    end
    if (idx_mode) begin
      if (is_digit(ch)) begin
        idx_acc  = add_digit(idx_seen, idx_acc, ch);
        idx_seen = 1'b1;
        return ActFeed;
      end
      // A closing brace right after the index asks for the item but stays in index mode.
      if (ch == ChClose) return ActItem;
      // Any other non-digit starts the spec; the colon is only consumed.
      idx_mode  = 1'b0;
      spec_mode = 1'b1;
      if (ch == ChColon) return ActFeed;
    end
    if (spec_mode) begin
      if (is_digit(ch)) begin
        val_acc  = add_digit(val_seen, val_acc, ch);
        val_seen = 1'b1;
        return ActFeed;
      end
      case (ch)
        ChClose: begin
          apply_value(1'b0);
          return ActItem;
        end
        ChBang:  keep_mark = 1'b1;
        ChMinus: ;
        ChW:     apply_value(1'b0);
        ChP:     apply_value(1'b1);
        // Alignment letters add their bit and leave the other alignment bits alone.
        ChL: begin
          apply_value(1'b0);
          cur_fmt.flags[FlLeft] = 1'b1;
        end
        ChR: begin
          apply_value(1'b0);
          cur_fmt.flags[FlRight] = 1'b1;
        end
        ChI: begin
          apply_value(1'b0);
          cur_fmt.flags[FlInternal] = 1'b1;
        end
        // Base letters replace the base; b is taken as hex.
        ChD:      cur_fmt.flags = (cur_fmt.flags & ~BaseMask) | (FlagsW'(1) << FlDec);
        ChO:      cur_fmt.flags = (cur_fmt.flags & ~BaseMask) | (FlagsW'(1) << FlOct);
        ChB, ChH: cur_fmt.flags = (cur_fmt.flags & ~BaseMask) | (FlagsW'(1) << FlHex);
        ChS:      cur_fmt.flags[FlSci] = 1'b1;
        ChF:      cur_fmt.flags[FlFixed] = 1'b1;
        ChX:      cur_fmt.flags[FlShowbase] = 1'b1;
        default:  cur_fmt.fill = ch;
      endcase
      // Whatever was not applied above is dropped by any non-digit.
      clear_value();
      return ActFeed;
    end
    if (ch == ChOpen) begin
      idx_mode = 1'b1;
      idx_seen = 1'b0;
      idx_acc  = 0;
      return ActFeed;
    end
    return ActPass;
  endfunction

  // Advances the model by one input word and returns the result word it owes.
  function automatic parse_result_t parse_word(in_word_t w);
    parse_result_t r;
    action_e       act;
    case (w.req)
      ReqChar: act = parse_char(w.ch, w.esc);
      ReqBegin: begin
        saved_fmt = cur_fmt;
        leave_spec();
        act = ActCtrl;
      end
      ReqAfter: begin
        // A keep mark lets the format outlive the item.
        if (!keep_mark) cur_fmt = saved_fmt;
        leave_spec();
        act = ActCtrl;
      end
      default: act = ActCtrl;
    endcase
    r.action    = act;
    r.arg_index = idx_seen ? sat_num(idx_acc) : '0;
    r.arg_valid = idx_seen;
    r.fmt       = cur_fmt;
    r.keep      = keep_mark;
    return r;
  endfunction

  task automatic push_word(req_e req, logic [CharW-1:0] ch, logic esc);
    stim.push_back(in_word_t'{req, ch, esc, 1'b0, ActFeed});
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < ReportLimit) begin
        $display("%0t: %s differs, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Sender. A word that is offered stays on the bus until it is taken; the next word is
  // offered, or the bus goes quiet, only once the current one has gone.
  always @(posedge clk_i) begin
    parse_result_t predicted;
    int            send_idle;
    send_idle = (idle_phase == 2'd0) ? 23 : (idle_phase == 2'd1) ? 66 : 0;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predicted = parse_word(stim[send_ptr]);
        if (stim[send_ptr].chk_dflt) begin
          predicted = parse_result_t'{stim[send_ptr].dflt_act, NumW'(0), 1'b0,
                                      FmtReset, 1'b0};
        end
        pending_results.push_back(predicted);
        send_ptr++;
        // The idle pattern moves on by thirds of the stimulus.
        idle_phase <= (send_ptr * 3 >= 2 * stim.size()) ? 2'd2 :
                      (send_ptr * 3 >= stim.size()) ? 2'd1 : 2'd0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_ptr < stim.size() && $urandom_range(99) >= send_idle) begin
          in_if.valid    <= 1'b1;
          in_if.req_type <= stim[send_ptr].req;
          in_if.char_in  <= stim[send_ptr].ch;
          in_if.escaped  <= stim[send_ptr].esc;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every result word taken is held against the oldest prediction.
  always @(posedge clk_i) begin
    parse_result_t want;
    int            recv_idle;
    recv_idle = (idle_phase == 2'd0) ? 66 : (idle_phase == 2'd1) ? 23 : 0;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("%0t: result word with none outstanding, action %0d",
                     $realtime, out_if.action);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("action", want.action, out_if.action);
          check_field("arg_index", want.arg_index, out_if.arg_index);
          check_field("arg_index_valid", want.arg_valid, out_if.arg_index_valid);
          check_field("field_width", want.fmt.width, out_if.field_width);
          check_field("field_precision", want.fmt.precision, out_if.field_precision);
          check_field("fill_char", want.fmt.fill, out_if.fill_char);
          check_field("format_flags", want.fmt.flags, out_if.format_flags);
          check_field("keep_flag", want.keep, out_if.keep_flag);
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: a long stretch with no word moving on either side means the block hangs
  // or owes results it will never deliver.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.req_type = ReqChar;
    in_if.char_in  = '0;
    in_if.escaped  = 1'b0;
    out_if.ready   = 1'b0;

    // Model in its reset state.
    leave_spec();
    cur_fmt   = FmtReset;
    saved_fmt = FmtReset;

    // Directed words: a walk through two specs that touches p, l, i, o, b, s, f, x, ! and -.
    dir_rows = '{
      // An unknown request changes nothing.
      '{ReqNone,  8'hFF,   1'b1, 1'b1, ActCtrl},
      // Plain and escaped text outside a spec pass through.
      '{ReqChar,  8'h41,   1'b0, 1'b1, ActPass},
      '{ReqChar,  8'h00,   1'b1, 1'b1, ActPass},
      '{ReqBegin, 8'h00,   1'b0, 1'b1, ActCtrl},
      '{ReqChar,  ChOpen,  1'b0, 1'b1, ActFeed},
      // Five nines overflow the index accumulator.
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      // An escape inside the index opens the spec and the byte becomes the fill.
      '{ReqChar,  8'hFF,   1'b1, 1'b0, ActFeed},
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChP,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChL,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChI,     1'b0, 1'b0, ActFeed},
      // The minus sign throws the pending value away.
      '{ReqChar,  ChNine,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChMinus, 1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChO,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChB,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChS,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChF,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChX,     1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChBang,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChClose, 1'b0, 1'b0, ActFeed},
      // With the keep mark set the after event leaves the format in place.
      '{ReqAfter, 8'h00,   1'b0, 1'b0, ActFeed},
      // An empty index asks for the item at once.
      '{ReqChar,  ChOpen,  1'b0, 1'b0, ActFeed},
      '{ReqChar,  ChClose, 1'b0, 1'b0, ActFeed},
      // No keep mark this time, so the format saved at the begin event comes back.
      '{ReqAfter, 8'h00,   1'b0, 1'b1, ActCtrl}
    };
    foreach (dir_rows[k]) stim.push_back(dir_rows[k]);

    // Random part. Mostly whole specs with random content, most of them between begin and
    // after events, so that they reach the index and format decode; some raw noise too.
    while (stim.size() < DirCount + RandWords) begin
      if ($urandom_range(99) < 15) begin
        push_word(req_e'($urandom_range(3)), CharW'($urandom), 1'($urandom));
      end else begin
        if ($urandom_range(3) != 0) push_word(ReqBegin, CharW'($urandom), 1'b0);
        repeat ($urandom_range(2)) begin
          push_word(ReqChar, CharW'($urandom), $urandom_range(9) == 0);
        end
        push_word(ReqChar, ChOpen, 1'b0);
        repeat ($urandom_range(6)) push_word(ReqChar, ChZero + CharW'($urandom_range(9)), 1'b0);
        if ($urandom_range(2) != 0) push_word(ReqChar, ChColon, 1'b0);
        repeat ($urandom_range(8)) begin
          pick = $urandom_range(9);
          if (pick < 3) begin
            repeat ($urandom_range(1, 6)) begin
              push_word(ReqChar, ChZero + CharW'($urandom_range(9)), 1'b0);
            end
          end else if (pick < 8) begin
            push_word(ReqChar, spec_chars[$urandom_range(13)], 1'b0);
          end else begin
            push_word(ReqChar, CharW'($urandom), pick == 8);
          end
        end
        if ($urandom_range(9) != 0) push_word(ReqChar, ChClose, 1'b0);
        if ($urandom_range(9) != 0) push_word(ReqAfter, CharW'($urandom), 1'b0);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every word went in and every result came back, then give a stray
    // extra result word the chance to show up.
    while (send_ptr < stim.size() || pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_if.sv
hw/rtl/brace_format_spec_parser.sv
tb/brace_format_spec_parser_test.sv
